@@ rtl/core/ffpa_pkg.sv @@
`timescale 1ns / 1ps
package ffpa_pkg;

	localparam int NODES      = 256;
	localparam int NODE_W     = $clog2(NODES);
	localparam int LINK_W     = NODE_W + 1;
	localparam int CNT_W      = NODE_W + 1;
	localparam int ADDR_W     = 20;
	localparam int SIZE_W     = 21;
	localparam int HDR_W      = 8;
	localparam int SLACK_W    = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int SUM_W      = SIZE_W + 2;

	localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(NODES);
	localparam logic [SIZE_W-1:0] POOL_CAP = SIZE_W'(1) << ADDR_W;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_ZERO      = 3'd1,
		ST_EXHAUSTED = 3'd2,
		ST_NO_DESC   = 3'd3,
		ST_NOT_ALLOC = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_POOL_SIZE    = 2'd0,
		CFG_HEADER_BYTES = 2'd1,
		CFG_SPLIT_SLACK  = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic [ADDR_W-1:0] offset;
		logic              is_free;
		logic [LINK_W-1:0] link;
	} node_t;

	typedef struct packed {
		logic [SIZE_W-1:0]  pool_size;
		logic [HDR_W-1:0]   header_bytes;
		logic [SLACK_W-1:0] split_slack;
	} cfg_t;

	typedef struct packed {
		logic              pop;
		logic              push;
		logic [NODE_W-1:0] push_idx;
	} spare_req_t;

	typedef struct packed {
		logic [CNT_W-1:0]  live_blocks;
		logic [SIZE_W-1:0] bytes_in_use;
		logic [ADDR_W-1:0] granted_address;
		status_t           status;
	} result_t;

endpackage

@@ rtl/core/ffpa_node_ram.sv @@
`timescale 1ns / 1ps
module ffpa_node_ram (
	input  logic                       clk,
	input  logic [ffpa_pkg::NODE_W-1:0] rd_addr,
	output ffpa_pkg::node_t            rd_data,
	input  logic                       wr_en,
	input  logic [ffpa_pkg::NODE_W-1:0] wr_addr,
	input  ffpa_pkg::node_t            wr_data
);

	ffpa_pkg::node_t mem [ffpa_pkg::NODES];
	ffpa_pkg::node_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/core/ffpa_spare.sv @@
`timescale 1ns / 1ps
module ffpa_spare (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ffpa_pkg::spare_req_t        req,
	output logic                        has_spare,
	output logic [ffpa_pkg::NODE_W-1:0] pop_idx
);

	logic [ffpa_pkg::NODE_W-1:0] mem [ffpa_pkg::NODES];
	logic [ffpa_pkg::CNT_W-1:0]  stack_cnt_q;
	logic [ffpa_pkg::CNT_W-1:0]  fresh_q;
	logic [ffpa_pkg::CNT_W-1:0]  top_pos;
	logic [ffpa_pkg::NODE_W-1:0] pop_idx_q;

	assign top_pos   = stack_cnt_q - ffpa_pkg::CNT_W'(1);
	assign has_spare = (stack_cnt_q != '0) || (fresh_q != ffpa_pkg::CNT_W'(ffpa_pkg::NODES));
	assign pop_idx   = pop_idx_q;

	// recycled indexes on a stack, never-used ones from a counter
	always_ff @(posedge clk) begin
		if (req.push) begin
			mem[stack_cnt_q[ffpa_pkg::NODE_W-1:0]] <= req.push_idx;
		end
		if (req.pop) begin
			if (stack_cnt_q != '0) begin
				pop_idx_q <= mem[top_pos[ffpa_pkg::NODE_W-1:0]];
			end else begin
				pop_idx_q <= fresh_q[ffpa_pkg::NODE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_cnt_q <= '0;
			fresh_q     <= '0;
		end else begin
			if (req.push) begin
				stack_cnt_q <= stack_cnt_q + ffpa_pkg::CNT_W'(1);
			end else if (req.pop) begin
				if (stack_cnt_q != '0) begin
					stack_cnt_q <= top_pos;
				end else begin
					fresh_q <= fresh_q + ffpa_pkg::CNT_W'(1);
				end
			end
		end
	end

endmodule

@@ rtl/core/ffpa_ctrl.sv @@
`timescale 1ns / 1ps
module ffpa_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        in_op,
	input  logic [ffpa_pkg::SIZE_W-1:0] in_request_size,
	input  logic [ffpa_pkg::ADDR_W-1:0] in_block_address,
	input  ffpa_pkg::cfg_t              cfg,
	output logic [ffpa_pkg::NODE_W-1:0] rd_addr,
	input  ffpa_pkg::node_t             rd_data,
	output logic                        wr_en,
	output logic [ffpa_pkg::NODE_W-1:0] wr_addr,
	output ffpa_pkg::node_t             wr_data,
	output ffpa_pkg::spare_req_t        spare_req,
	input  logic                        has_spare,
	input  logic [ffpa_pkg::NODE_W-1:0] pop_idx,
	output logic                        res_valid,
	input  logic                        res_ready,
	output ffpa_pkg::result_t           res
);

	typedef enum logic [3:0] {
		S_IDLE, S_STEP, S_CHK, S_SPLIT_A, S_SPLIT_B, S_APP_CHK, S_APP_WR, S_APP_LNK,
		S_FNX, S_FPRV, S_FIN
	} state_t;

	state_t                      state_q;
	logic                        op_q;
	logic [ffpa_pkg::SIZE_W-1:0] req_q;
	logic [ffpa_pkg::ADDR_W-1:0] addr_q;
	logic [ffpa_pkg::LINK_W-1:0] cur_q;
	logic [ffpa_pkg::LINK_W-1:0] prev_q;
	ffpa_pkg::node_t             cur_ent_q;
	ffpa_pkg::node_t             prev_ent_q;
	logic [ffpa_pkg::NODE_W-1:0] new_q;
	logic [ffpa_pkg::LINK_W-1:0] head_q;
	logic [ffpa_pkg::SIZE_W-1:0] bump_q;
	logic [ffpa_pkg::SIZE_W-1:0] used_q;
	logic [ffpa_pkg::CNT_W-1:0]  count_q;
	ffpa_pkg::status_t           status_q;
	logic [ffpa_pkg::ADDR_W-1:0] granted_q;

	logic                        is_alloc;
	logic                        fit;
	logic [ffpa_pkg::SIZE_W-1:0] excess;
	logic [ffpa_pkg::SIZE_W-1:0] cur_excess;
	logic                        do_split;
	logic                        split_now;
	logic [ffpa_pkg::SIZE_W-1:0] limit;
	logic [ffpa_pkg::SUM_W-1:0]  app_end;
	logic                        prev_merge;

	assign is_alloc   = (op_q == ffpa_pkg::OP_ALLOC);
	assign fit        = rd_data.is_free && (rd_data.size >= req_q);
	assign excess     = rd_data.size - req_q;
	assign cur_excess = cur_ent_q.size - req_q;
	assign do_split   = (excess > ffpa_pkg::SIZE_W'(cfg.split_slack))
		&& (excess > ffpa_pkg::SIZE_W'(cfg.header_bytes));
	assign split_now  = do_split && has_spare;
	assign limit      = (cfg.pool_size > ffpa_pkg::POOL_CAP) ? ffpa_pkg::POOL_CAP : cfg.pool_size;
	assign app_end    = ffpa_pkg::SUM_W'(bump_q) + ffpa_pkg::SUM_W'(req_q)
		+ ffpa_pkg::SUM_W'(cfg.header_bytes);
	assign prev_merge = (prev_q != ffpa_pkg::NIL_LINK) && prev_ent_q.is_free;

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_FIN);
	assign res.status          = status_q;
	assign res.granted_address = granted_q;
	assign res.bytes_in_use    = used_q;
	assign res.live_blocks     = count_q;

	always_comb begin
		rd_addr   = cur_q[ffpa_pkg::NODE_W-1:0];
		wr_en     = 1'b0;
		wr_addr   = cur_q[ffpa_pkg::NODE_W-1:0];
		wr_data   = rd_data;
		spare_req = '0;
		case (state_q)
			S_CHK: begin
				rd_addr = rd_data.link[ffpa_pkg::NODE_W-1:0];
				if (is_alloc && fit) begin
					if (split_now) begin
						spare_req.pop = 1'b1;
					end else begin
						wr_en           = 1'b1;
						wr_data.is_free = 1'b0;
					end
				end
			end
			S_SPLIT_A: begin
				wr_en          = 1'b1;
				wr_addr        = pop_idx;
				wr_data.offset = ffpa_pkg::ADDR_W'(cur_ent_q.offset + req_q[ffpa_pkg::ADDR_W-1:0]
					+ ffpa_pkg::ADDR_W'(cfg.header_bytes));
				wr_data.size    = cur_excess - ffpa_pkg::SIZE_W'(cfg.header_bytes);
				wr_data.is_free = 1'b1;
				wr_data.link    = cur_ent_q.link;
			end
			S_SPLIT_B: begin
				wr_en           = 1'b1;
				wr_data         = cur_ent_q;
				wr_data.size    = req_q;
				wr_data.is_free = 1'b0;
				wr_data.link    = {1'b0, new_q};
			end
			S_APP_CHK: begin
				if (app_end <= ffpa_pkg::SUM_W'(limit) && has_spare) begin
					spare_req.pop = 1'b1;
				end
			end
			S_APP_WR: begin
				wr_en           = 1'b1;
				wr_addr         = pop_idx;
				wr_data.size    = req_q;
				wr_data.offset  = bump_q[ffpa_pkg::ADDR_W-1:0];
				wr_data.is_free = 1'b0;
				wr_data.link    = ffpa_pkg::NIL_LINK;
			end
			S_APP_LNK: begin
				wr_en        = 1'b1;
				wr_addr      = prev_q[ffpa_pkg::NODE_W-1:0];
				wr_data      = prev_ent_q;
				wr_data.link = {1'b0, new_q};
			end
			S_FNX: begin
				if (rd_data.is_free) begin
					spare_req.push     = 1'b1;
					spare_req.push_idx = cur_ent_q.link[ffpa_pkg::NODE_W-1:0];
				end
			end
			S_FPRV: begin
				wr_en = 1'b1;
				if (prev_merge) begin
					wr_addr      = prev_q[ffpa_pkg::NODE_W-1:0];
					wr_data      = prev_ent_q;
					wr_data.size = prev_ent_q.size + cur_ent_q.size
						+ ffpa_pkg::SIZE_W'(cfg.header_bytes);
					wr_data.link       = cur_ent_q.link;
					spare_req.push     = 1'b1;
					spare_req.push_idx = cur_q[ffpa_pkg::NODE_W-1:0];
				end else begin
					wr_data = cur_ent_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= ffpa_pkg::NIL_LINK;
			bump_q     <= '0;
			used_q     <= '0;
			count_q    <= '0;
			status_q   <= ffpa_pkg::ST_OK;
			granted_q  <= '0;
			op_q       <= 1'b0;
			req_q      <= '0;
			addr_q     <= '0;
			cur_q      <= ffpa_pkg::NIL_LINK;
			prev_q     <= ffpa_pkg::NIL_LINK;
			cur_ent_q  <= '0;
			prev_ent_q <= '0;
			new_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q      <= in_op;
						req_q     <= in_request_size;
						addr_q    <= in_block_address;
						cur_q     <= head_q;
						prev_q    <= ffpa_pkg::NIL_LINK;
						granted_q <= '0;
						if (in_op == ffpa_pkg::OP_ALLOC && in_request_size == '0) begin
							status_q <= ffpa_pkg::ST_ZERO;
							state_q  <= S_FIN;
						end else begin
							status_q <= ffpa_pkg::ST_OK;
							state_q  <= S_STEP;
						end
					end
				end
				S_STEP: begin
					if (cur_q != ffpa_pkg::NIL_LINK) begin
						state_q <= S_CHK;
					end else if (is_alloc) begin
						state_q <= S_APP_CHK;
					end else begin
						status_q <= ffpa_pkg::ST_NOT_ALLOC;
						state_q  <= S_FIN;
					end
				end
				S_CHK: begin
					if (is_alloc && fit) begin
						cur_ent_q <= rd_data;
						if (split_now) begin
							state_q <= S_SPLIT_A;
						end else begin
							used_q    <= used_q + rd_data.size;
							granted_q <= rd_data.offset;
							state_q   <= S_FIN;
						end
					end else if (!is_alloc && rd_data.offset == addr_q) begin
						if (rd_data.is_free) begin
							status_q <= ffpa_pkg::ST_NOT_ALLOC;
							state_q  <= S_FIN;
						end else begin
							cur_ent_q <= {rd_data.size, rd_data.offset, 1'b1, rd_data.link};
							used_q <= (rd_data.size <= used_q) ? used_q - rd_data.size : '0;
							state_q <= (rd_data.link != ffpa_pkg::NIL_LINK) ? S_FNX : S_FPRV;
						end
					end else begin
						prev_q     <= cur_q;
						prev_ent_q <= rd_data;
						cur_q      <= rd_data.link;
						if (rd_data.link == ffpa_pkg::NIL_LINK) begin
							if (is_alloc) begin
								state_q <= S_APP_CHK;
							end else begin
								status_q <= ffpa_pkg::ST_NOT_ALLOC;
								state_q  <= S_FIN;
							end
						end
					end
				end
				S_SPLIT_A: begin
					new_q   <= pop_idx;
					state_q <= S_SPLIT_B;
				end
				S_SPLIT_B: begin
					used_q    <= used_q + req_q;
					count_q   <= count_q + ffpa_pkg::CNT_W'(1);
					granted_q <= cur_ent_q.offset;
					state_q   <= S_FIN;
				end
				S_APP_CHK: begin
					if (app_end > ffpa_pkg::SUM_W'(limit)) begin
						status_q <= ffpa_pkg::ST_EXHAUSTED;
						state_q  <= S_FIN;
					end else if (!has_spare) begin
						status_q <= ffpa_pkg::ST_NO_DESC;
						state_q  <= S_FIN;
					end else begin
						state_q <= S_APP_WR;
					end
				end
				S_APP_WR: begin
					new_q     <= pop_idx;
					bump_q    <= app_end[ffpa_pkg::SIZE_W-1:0];
					used_q    <= used_q + req_q;
					count_q   <= count_q + ffpa_pkg::CNT_W'(1);
					granted_q <= bump_q[ffpa_pkg::ADDR_W-1:0];
					if (prev_q == ffpa_pkg::NIL_LINK) begin
						head_q  <= {1'b0, pop_idx};
						state_q <= S_FIN;
					end else begin
						state_q <= S_APP_LNK;
					end
				end
				S_APP_LNK: begin
					state_q <= S_FIN;
				end
				S_FNX: begin
					if (rd_data.is_free) begin
						cur_ent_q.size <= cur_ent_q.size + rd_data.size
							+ ffpa_pkg::SIZE_W'(cfg.header_bytes);
						cur_ent_q.link <= rd_data.link;
						if (count_q != '0) begin
							count_q <= count_q - ffpa_pkg::CNT_W'(1);
						end
					end
					state_q <= S_FPRV;
				end
				S_FPRV: begin
					if (prev_merge && count_q != '0) begin
						count_q <= count_q - ffpa_pkg::CNT_W'(1);
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_pop_has_spare: assert property (@(posedge clk) disable iff (!arst_n)
		spare_req.pop |-> has_spare)
		else $error("descriptor taken with none spare");
	a_no_push_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(spare_req.pop && spare_req.push))
		else $error("descriptor taken and returned together");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ffpa_pkg::CNT_W'(ffpa_pkg::NODES))
		else $error("live block count overflow");
	a_ok_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && status_q != ffpa_pkg::ST_OK) |-> (granted_q == '0))
		else $error("address granted on failed request");
`endif

endmodule

@@ rtl/core/first_fit_pool_allocator.sv @@
`timescale 1ns / 1ps
// first-fit allocator over a pool of up to 2^20 bytes with up to 256 block descriptors
// kept in an address-ordered list in a node memory with one read and one write port. one
// request at a time: the list is walked one descriptor at a time through the read port; a
// split writes the new and the old descriptor, an append writes a new one and links any last
// one to it, a free merges its block with free neighbours. results are held in an output
// register, so a waiting result stalls only the next request. no clearing pass after reset.
// config writes are taken every cycle and must only be made while idle.
module first_fit_pool_allocator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [47:0]                          s_tdata,   // request_size, block_address
	input  logic                                 s_tuser,   // op
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [55:0]                          m_tdata,   // status, granted_address, bytes_in_use, live_blocks
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ffpa_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ffpa_pkg::SIZE_W-1:0]          cfg_data
);

	ffpa_pkg::cfg_t              cfg_q;
	logic                        m_tvalid_q;
	ffpa_pkg::result_t           m_res_q;
	logic [ffpa_pkg::NODE_W-1:0] rd_addr;
	ffpa_pkg::node_t             rd_data;
	logic                        wr_en;
	logic [ffpa_pkg::NODE_W-1:0] wr_addr;
	ffpa_pkg::node_t             wr_data;
	ffpa_pkg::spare_req_t        spare_req;
	logic                        has_spare;
	logic [ffpa_pkg::NODE_W-1:0] pop_idx;
	logic                        res_valid;
	logic                        res_ready;
	ffpa_pkg::result_t           res;

	assign cfg_ready = 1'b1;
	assign res_ready = !m_tvalid_q || m_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {3'b000, m_res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pool_size    <= ffpa_pkg::SIZE_W'(1048576);
			cfg_q.header_bytes <= ffpa_pkg::HDR_W'(32);
			cfg_q.split_slack  <= ffpa_pkg::SLACK_W'(64);
		end else if (cfg_valid) begin
			case (cfg_index)
				ffpa_pkg::CFG_POOL_SIZE:    cfg_q.pool_size    <= cfg_data;
				ffpa_pkg::CFG_HEADER_BYTES: cfg_q.header_bytes <= cfg_data[ffpa_pkg::HDR_W-1:0];
				ffpa_pkg::CFG_SPLIT_SLACK:  cfg_q.split_slack  <= cfg_data[ffpa_pkg::SLACK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_res_q <= res;
		end
	end

	ffpa_ctrl u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (s_tvalid),
		.in_ready         (s_tready),
		.in_op            (s_tuser),
		.in_request_size  (s_tdata[20:0]),
		.in_block_address (s_tdata[40:21]),
		.cfg              (cfg_q),
		.rd_addr          (rd_addr),
		.rd_data          (rd_data),
		.wr_en            (wr_en),
		.wr_addr          (wr_addr),
		.wr_data          (wr_data),
		.spare_req        (spare_req),
		.has_spare        (has_spare),
		.pop_idx          (pop_idx),
		.res_valid        (res_valid),
		.res_ready        (res_ready),
		.res              (res)
	);

	ffpa_node_ram u_node_ram (
		.clk     (clk),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	ffpa_spare u_spare (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (spare_req),
		.has_spare (has_spare),
		.pop_idx   (pop_idx)
	);

endmodule
